[rtl/csv_field_splitter_core_defines.svh]
// Assertion macros used by the CSV field splitter core.
`ifndef CSV_FIELD_SPLITTER_CORE_DEFINES_SVH
`define CSV_FIELD_SPLITTER_CORE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define CSVFS_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("csvfs same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define CSVFS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("csvfs next-cycle check failed");

`endif

[rtl/csvfs_pkg.sv]
package csvfs_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 256;
    localparam int unsigned KEPT_W = $clog2(MAX_FIELD_BYTES + 1);

    typedef logic [7:0]        t_byte;
    typedef logic [KEPT_W-1:0] t_kept;

    localparam t_kept KEPT_MAX = t_kept'(MAX_FIELD_BYTES);

    localparam t_byte CH_QUOTE    = 8'h22;
    localparam t_byte CH_LF       = 8'h0A;
    localparam t_byte CH_CR       = 8'h0D;
    localparam t_byte DELIM_RESET = 8'h2C;

    // One result item.
    typedef struct packed {
        t_byte out_byte;
        logic  has_byte;
        logic  field_end;
        logic  field_empty;
        logic  truncated;
        logic  stream_done;
    } t_result;

endpackage

[rtl/csvfs_if.sv]
interface csvfs_in_if;
    logic                 valid;
    logic                 ready;
    csvfs_pkg::t_byte     data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface csvfs_out_if;
    logic                 valid;
    logic                 ready;
    csvfs_pkg::t_byte     out_byte;
    logic                 has_byte;
    logic                 field_end;
    logic                 field_empty;
    logic                 truncated;
    logic                 stream_done;

    modport source (output valid, output out_byte, output has_byte, output field_end,
                    output field_empty, output truncated, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input field_end,
                    input field_empty, input truncated, input stream_done,
                    output ready);
endinterface

interface csvfs_cfg_if;
    logic                 valid;
    logic                 ready;
    csvfs_pkg::t_byte     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/csv_field_splitter_core.sv]
// Channel   Direction  Payload
// i_in      sink       data_byte[7:0], last_byte
// o_out     source     out_byte[7:0], has_byte, field_end, field_empty, truncated,
//                      stream_done
// i_cfg     sink       data[7:0] (field delimiter)
//
// One byte is taken per clock while i_in.ready is high. A byte is captured in the input
// register, and its result is registered in the output register when the byte advances.
// Reset (i_rst_n low, synchronous) empties both registers, clears the parser flags
// and sets the delimiter to a comma.
// A waiting result with o_out.ready low holds a result-making byte in the input
// register and drops i_in.ready; bytes that make no result still pass.
`include "csv_field_splitter_core_defines.svh"

module csv_field_splitter_core (
    input  logic i_clk,
    input  logic i_rst_n,
    csvfs_in_if.sink    i_in,
    csvfs_out_if.source o_out,
    csvfs_cfg_if.sink   i_cfg
);
    import csvfs_pkg::*;

    // Delimiter register. The user must write it only while the core is idle; the block
    // itself does not enforce this, and the channel is always ready.
    t_byte r_delim;

    // Input register.
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;

    // Parser state.
    logic  r_at_field_start, n_at_field_start;
    logic  r_quoted_field,   n_quoted_field;
    logic  r_quote_closed,   n_quote_closed;
    logic  r_trail_pending,  n_trail_pending;
    logic  r_swallow_lf,     n_swallow_lf;
    t_kept r_kept_count,     n_kept_count;
    logic  r_overflowed,     n_overflowed;

    // Output register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic produce;
    logic advance;

    // Single-pass parse of the byte held in the input register.
    always_comb begin
        logic sep;
        logic keep;
        logic ended;
        logic by_sep;

        sep    = (r_in_byte == r_delim) || (r_in_byte == CH_LF) || (r_in_byte == CH_CR);
        keep   = 1'b0;
        ended  = 1'b0;
        by_sep = 1'b0;

        n_at_field_start = r_at_field_start;
        n_quoted_field   = r_quoted_field;
        n_quote_closed   = r_quote_closed;
        n_trail_pending  = r_trail_pending;
        n_swallow_lf     = 1'b0;
        n_kept_count     = r_kept_count;
        n_overflowed     = r_overflowed;
        n_out            = '0;

        if (r_swallow_lf && (r_in_byte == CH_LF)) begin
            // LF right after a field-ending separator (as in CR LF): dropped, no byte kept.
        end else if (r_trail_pending) begin
            n_trail_pending = 1'b0;
            keep            = 1'b1;
        end else if (r_at_field_start && (r_in_byte == CH_QUOTE)) begin
            n_at_field_start = 1'b0;
            n_quoted_field   = 1'b1;
        end else begin
            n_at_field_start = 1'b0;
            if (r_in_byte[7]) begin
                // Lead byte of a two-byte character.
                n_trail_pending = 1'b1;
                keep            = 1'b1;
            end else if (r_quoted_field) begin
                if (r_in_byte == CH_QUOTE) begin
                    n_quote_closed = !r_quote_closed;
                end
                if (n_quote_closed) begin
                    if (sep) begin
                        ended  = 1'b1;
                        by_sep = 1'b1;
                    end
                end else begin
                    keep = 1'b1;
                end
            end else if (sep) begin
                ended  = 1'b1;
                by_sep = 1'b1;
            end else begin
                keep = 1'b1;
            end
        end

        if (keep) begin
            if (r_kept_count < KEPT_MAX) begin
                n_kept_count   = r_kept_count + t_kept'(1);
                n_out.has_byte = 1'b1;
                n_out.out_byte = r_in_byte;
            end else begin
                n_overflowed = 1'b1;
            end
        end

        if (r_in_last) begin
            ended = 1'b1;
        end

        if (ended) begin
            // The count already includes a byte kept in this same step.
            n_out.field_end   = 1'b1;
            n_out.field_empty = (n_kept_count == '0);
            n_out.truncated   = n_overflowed;
            n_at_field_start  = 1'b1;
            n_quoted_field    = 1'b0;
            n_quote_closed    = 1'b0;
            n_trail_pending   = 1'b0;
            n_kept_count      = '0;
            n_overflowed      = 1'b0;
            n_swallow_lf      = by_sep && !r_in_last;
        end

        n_out.stream_done = r_in_last;
        produce = n_out.has_byte || ended;
    end

    // The held byte moves on when its result has a free slot, or when it makes
    // no result at all.
    assign advance    = r_in_valid && (!produce || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim          <= DELIM_RESET;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_at_field_start <= 1'b1;
            r_quoted_field   <= 1'b0;
            r_quote_closed   <= 1'b0;
            r_trail_pending  <= 1'b0;
            r_swallow_lf     <= 1'b0;
            r_kept_count     <= '0;
            r_overflowed     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_delim <= i_cfg.data;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_at_field_start <= n_at_field_start;
                r_quoted_field   <= n_quoted_field;
                r_quote_closed   <= n_quote_closed;
                r_trail_pending  <= n_trail_pending;
                r_swallow_lf     <= n_swallow_lf;
                r_kept_count     <= n_kept_count;
                r_overflowed     <= n_overflowed;
            end
            if (advance && produce) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (advance && produce) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out.out_byte;
    assign o_out.has_byte    = r_out.has_byte;
    assign o_out.field_end   = r_out.field_end;
    assign o_out.field_empty = r_out.field_empty;
    assign o_out.truncated   = r_out.truncated;
    assign o_out.stream_done = r_out.stream_done;

    // Empty and truncated flags only ever travel with a field end.
    `CSVFS_ASSERT_SAME(a_flags_need_end, i_clk, i_rst_n,
        r_out_valid && (r_out.field_empty || r_out.truncated), r_out.field_end)
    // A result without a kept byte carries a zero byte.
    `CSVFS_ASSERT_SAME(a_zero_byte, i_clk, i_rst_n,
        r_out_valid && !r_out.has_byte, r_out.out_byte == '0)
    // The fill count never passes the field buffer size.
    `CSVFS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_kept_count <= KEPT_MAX)
    // After the last byte of a stream the parser is back at a clean field start.
    `CSVFS_ASSERT_NEXT(a_stream_restart, i_clk, i_rst_n, advance && r_in_last,
        r_at_field_start && !r_quoted_field && !r_trail_pending && !r_swallow_lf
        && (r_kept_count == '0) && !r_overflowed)

endmodule
